>>> rtl/imu_frame_qualify_calibrate_unit_macros.svh
// assertion macros for the imu frame qualify and calibrate block
// used by the port checker; needs nothing else
`ifndef IMU_FRAME_QUALIFY_CALIBRATE_UNIT_MACROS_SVH
`define IMU_FRAME_QUALIFY_CALIBRATE_UNIT_MACROS_SVH

// same-cycle implication, off while reset is held
`define IFQC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define IFQC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ifqc_pkg.sv
// types and constants of the imu frame qualify and calibrate block
// no dependencies; used by the interfaces, the top level and the checker
package ifqc_pkg;

    // field widths
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_W         = 25;
    localparam int OFS_W           = 26;
    localparam int SCL_W           = 19;
    localparam int SCL_FRAC        = 16;
    localparam int OUT_W           = 27;
    localparam int TEMP_IN_W       = 16;
    localparam int TEMP_OUT_W      = 14;
    localparam int TEMP_FRAC       = 8;
    localparam int GRAV_W          = 3;
    localparam int CODE_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 26;

    // datapath widths
    localparam int SUM_W   = 27;              // angle plus offset
    localparam int PROD_W  = SUM_W + SCL_W;   // exact product
    localparam int WORK_W  = 32;              // rounded, saturated angle
    localparam int LEVEL_W = WORK_W + 1;      // level angle before and after wrap

    // temperature filter: t = (48 t + s + s_last + 25) / 50
    localparam int TEMP_HIST_WEIGHT = 48;
    localparam int TEMP_ROUND       = 25;
    localparam int TEMP_DIV         = 50;
    localparam int NUM_W            = 20;     // numerator stays below 2**20
    localparam int RECIP_SHIFT      = 26;
    localparam int RECIP_W          = 21;
    // exact floor division for numerators below 2**26 / 36
    localparam int TEMP_RECIP = ((2 ** RECIP_SHIFT) + TEMP_DIV - 1) / TEMP_DIV;

    typedef logic signed [ANGLE_W-1:0]   t_angle;
    typedef logic signed [OFS_W-1:0]     t_offset;
    typedef logic signed [SCL_W-1:0]     t_scale;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [PROD_W:0]      t_prod_rnd;
    typedef logic signed [WORK_W-1:0]    t_work;
    typedef logic signed [LEVEL_W-1:0]   t_level;
    typedef logic signed [OUT_W-1:0]     t_cal;
    typedef logic signed [TEMP_IN_W-1:0] t_temp_in;
    typedef logic [TEMP_OUT_W-1:0]       t_temp;
    typedef logic [GRAV_W-1:0]           t_gravity;
    typedef logic [CODE_W-1:0]           t_code;
    typedef logic [NUM_W-1:0]            t_num;
    typedef logic [NUM_W+RECIP_W-1:0]    t_qprod;
    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]       t_cfg_data;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_SCALE_X  = 3'd3,
        REG_SCALE_Y  = 3'd4,
        REG_SCALE_Z  = 3'd5
    } t_cfg_reg;

    // frame status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // gravity codes
    localparam t_code    GRAV_MAX    = 8'd6;
    localparam t_gravity GRAV_ROT_A  = 3'd1;   // horizontal taken from -z
    localparam t_gravity GRAV_ROT_B  = 3'd4;
    localparam t_gravity GRAV_FLAT_A = 3'd0;   // vertical taken from 90 - z
    localparam t_gravity GRAV_FLAT_B = 3'd3;

    // angle limits, degrees scaled by the fraction bits
    localparam t_work  ANGLE_LIMIT = t_work'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam t_work  CAL_LIMIT   = t_work'(720 * (2 ** ANGLE_FRAC_BITS));
    localparam t_work  NINETY      = t_work'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam t_level LEVEL_HALF  = t_level'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam t_level LEVEL_FULL  = t_level'(360 * (2 ** ANGLE_FRAC_BITS));

    localparam t_prod_rnd ROUND_HALF = t_prod_rnd'(2 ** (SCL_FRAC - 1));
    localparam t_scale    SCALE_ONE  = t_scale'(2 ** SCL_FRAC);

    // accepted temperature window, celsius q8.8
    localparam t_temp_in TEMP_MIN = t_temp_in'(10 * (2 ** TEMP_FRAC));
    localparam t_temp_in TEMP_MAX = t_temp_in'(60 * (2 ** TEMP_FRAC));
    localparam t_temp    TEMP_OUT_MAX = t_temp'(60 * (2 ** TEMP_FRAC));

endpackage

>>> rtl/ifqc_in_if.sv
// input channel of the imu frame qualify and calibrate block
// depends on ifqc_pkg
interface ifqc_in_if;
    logic                valid;
    logic                ready;
    ifqc_pkg::t_angle    rt_angle_x;
    ifqc_pkg::t_angle    rt_angle_y;
    ifqc_pkg::t_angle    rt_angle_z;
    ifqc_pkg::t_angle    disp_angle_x;
    ifqc_pkg::t_angle    disp_angle_y;
    ifqc_pkg::t_angle    disp_angle_z;
    ifqc_pkg::t_temp_in  raw_temperature;
    ifqc_pkg::t_code     gravity_code;

    modport source (
        output valid, rt_angle_x, rt_angle_y, rt_angle_z,
        output disp_angle_x, disp_angle_y, disp_angle_z,
        output raw_temperature, gravity_code,
        input  ready
    );

    modport sink (
        input  valid, rt_angle_x, rt_angle_y, rt_angle_z,
        input  disp_angle_x, disp_angle_y, disp_angle_z,
        input  raw_temperature, gravity_code,
        output ready
    );
endinterface

>>> rtl/ifqc_out_if.sv
// output channel of the imu frame qualify and calibrate block
// depends on ifqc_pkg
interface ifqc_out_if;
    logic                valid;
    logic                ready;
    logic                frame_status;
    ifqc_pkg::t_gravity  gravity_now;
    ifqc_pkg::t_gravity  gravity_rotation;
    ifqc_pkg::t_cal      cal_x;
    ifqc_pkg::t_cal      cal_y;
    ifqc_pkg::t_cal      cal_z;
    ifqc_pkg::t_cal      level_horizontal;
    ifqc_pkg::t_cal      level_vertical;
    ifqc_pkg::t_cal      show_horizontal;
    ifqc_pkg::t_cal      show_vertical;
    ifqc_pkg::t_temp     filtered_temperature;

    modport source (
        output valid, frame_status, gravity_now, gravity_rotation,
        output cal_x, cal_y, cal_z,
        output level_horizontal, level_vertical, show_horizontal, show_vertical,
        output filtered_temperature,
        input  ready
    );

    modport sink (
        input  valid, frame_status, gravity_now, gravity_rotation,
        input  cal_x, cal_y, cal_z,
        input  level_horizontal, level_vertical, show_horizontal, show_vertical,
        input  filtered_temperature,
        output ready
    );
endinterface

>>> rtl/imu_frame_qualify_calibrate_unit.sv
// imu frame qualify and calibrate block, top level
// depends on ifqc_pkg, ifqc_in_if and ifqc_out_if
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+-------------------------------------------
//  i_in      | in  | valid/ready        | six angles, raw temperature, gravity code
//  o_out     | out | valid/ready        | status, gravity, calibrated and level angles, filtered temperature
//  i_cfg_*   | in  | write enable only  | register index and data, no read-back
//
// one word per cycle sustained while the output is taken; a word that stalls holds its register
// the path is input register, state update, offset-and-scale multipliers, round/level/wrap
// each of the four registers holds while the one after it is full and not moving,
// so the input keeps taking words until all four hold a word
// synchronous active-low reset empties the pipe, clears the kept state and the
// temperature filter and loads offset 0 and scale 1.0
module imu_frame_qualify_calibrate_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ifqc_in_if.sink               i_in,
    ifqc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  ifqc_pkg::t_cfg_idx    i_cfg_index,
    input  ifqc_pkg::t_cfg_data   i_cfg_data
);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // round to nearest (ties up), drop the scale fraction, clamp to +-720 deg
    function automatic ifqc_pkg::t_work cal_round_sat(input ifqc_pkg::t_prod p);
        ifqc_pkg::t_prod_rnd t;
        ifqc_pkg::t_work     r;
        t = ifqc_pkg::t_prod_rnd'(p) + ifqc_pkg::ROUND_HALF;
        r = ifqc_pkg::t_work'(signed'(t[ifqc_pkg::PROD_W:ifqc_pkg::SCL_FRAC]));
        if (r > ifqc_pkg::CAL_LIMIT) begin
            r = ifqc_pkg::CAL_LIMIT;
        end else if (r < -ifqc_pkg::CAL_LIMIT) begin
            r = -ifqc_pkg::CAL_LIMIT;
        end
        return r;
    endfunction

    // a single +-360 deg correction
    function automatic ifqc_pkg::t_level level_wrap(input ifqc_pkg::t_level x);
        ifqc_pkg::t_level r;
        r = x;
        if (x > ifqc_pkg::LEVEL_HALF) begin
            r = x - ifqc_pkg::LEVEL_FULL;
        end else if (x < -ifqc_pkg::LEVEL_HALF) begin
            r = x + ifqc_pkg::LEVEL_FULL;
        end
        return r;
    endfunction

    function automatic ifqc_pkg::t_level level_h(
        input ifqc_pkg::t_work    cy,
        input ifqc_pkg::t_work    cz,
        input ifqc_pkg::t_gravity g
    );
        ifqc_pkg::t_level v;
        if (g == ifqc_pkg::GRAV_ROT_A || g == ifqc_pkg::GRAV_ROT_B) begin
            v = -ifqc_pkg::t_level'(cz);
        end else begin
            v = ifqc_pkg::t_level'(cy);
        end
        return level_wrap(v);
    endfunction

    function automatic ifqc_pkg::t_level level_v(
        input ifqc_pkg::t_work    cx,
        input ifqc_pkg::t_work    cz,
        input ifqc_pkg::t_gravity g
    );
        ifqc_pkg::t_level v;
        if (g == ifqc_pkg::GRAV_FLAT_A || g == ifqc_pkg::GRAV_FLAT_B) begin
            v = ifqc_pkg::t_level'(ifqc_pkg::NINETY) - ifqc_pkg::t_level'(cz);
        end else begin
            v = ifqc_pkg::t_level'(cx);
        end
        return level_wrap(v);
    endfunction

    function automatic logic angle_bad(input ifqc_pkg::t_angle a);
        ifqc_pkg::t_work w;
        w = ifqc_pkg::t_work'(a);
        return (a == '0) || (w > ifqc_pkg::ANGLE_LIMIT) || (w < -ifqc_pkg::ANGLE_LIMIT);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    ifqc_pkg::t_offset r_ofs [3];
    ifqc_pkg::t_scale  r_scl [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_ofs[a] <= '0;
                r_scl[a] <= ifqc_pkg::SCALE_ONE;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ifqc_pkg::REG_OFFSET_X: r_ofs[0] <= signed'(i_cfg_data);
                ifqc_pkg::REG_OFFSET_Y: r_ofs[1] <= signed'(i_cfg_data);
                ifqc_pkg::REG_OFFSET_Z: r_ofs[2] <= signed'(i_cfg_data);
                ifqc_pkg::REG_SCALE_X:  r_scl[0] <= signed'(i_cfg_data[ifqc_pkg::SCL_W-1:0]);
                ifqc_pkg::REG_SCALE_Y:  r_scl[1] <= signed'(i_cfg_data[ifqc_pkg::SCL_W-1:0]);
                ifqc_pkg::REG_SCALE_Z:  r_scl[2] <= signed'(i_cfg_data[ifqc_pkg::SCL_W-1:0]);
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipe control: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic ld1, ld2, ld3, ld4;

    assign ld4 = !r_v4 || o_out.ready;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign i_in.ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_in.valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    ifqc_pkg::t_angle   r_s1_rt   [3];
    ifqc_pkg::t_angle   r_s1_disp [3];
    ifqc_pkg::t_temp_in r_s1_temp;
    ifqc_pkg::t_code    r_s1_grav;

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_rt[0]   <= i_in.rt_angle_x;
            r_s1_rt[1]   <= i_in.rt_angle_y;
            r_s1_rt[2]   <= i_in.rt_angle_z;
            r_s1_disp[0] <= i_in.disp_angle_x;
            r_s1_disp[1] <= i_in.disp_angle_y;
            r_s1_disp[2] <= i_in.disp_angle_z;
            r_s1_temp    <= i_in.raw_temperature;
            r_s1_grav    <= i_in.gravity_code;
        end
    end

    // frame check: gravity code, temperature window, every angle nonzero and within +-180
    logic s1_ok;
    logic s1_angles_ok;

    always_comb begin
        s1_angles_ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (angle_bad(r_s1_rt[a]) || angle_bad(r_s1_disp[a])) begin
                s1_angles_ok = 1'b0;
            end
        end
        s1_ok = s1_angles_ok
             && (r_s1_grav <= ifqc_pkg::GRAV_MAX)
             && (r_s1_temp >= ifqc_pkg::TEMP_MIN)
             && (r_s1_temp <= ifqc_pkg::TEMP_MAX);
    end

    // ------------------------------------------------------------------
    // kept state, written as a good frame moves into stage 2
    // ------------------------------------------------------------------
    ifqc_pkg::t_angle   r_kept_rt   [3];
    ifqc_pkg::t_angle   r_kept_disp [3];
    ifqc_pkg::t_gravity r_kept_grav;
    ifqc_pkg::t_gravity r_kept_rot;
    ifqc_pkg::t_temp    r_temp_value;
    ifqc_pkg::t_temp    r_temp_prev;
    logic               r_temp_primed;

    logic               upd;
    ifqc_pkg::t_temp    s1_sample;
    ifqc_pkg::t_gravity s1_grav;
    ifqc_pkg::t_num     temp_num;
    ifqc_pkg::t_qprod   temp_qprod;
    ifqc_pkg::t_temp    temp_next;

    assign upd       = r_v1 && ld2 && s1_ok;
    // a good sample lies in 10..60 C, so it fits the unsigned filter width
    assign s1_sample = r_s1_temp[ifqc_pkg::TEMP_OUT_W-1:0];
    assign s1_grav   = r_s1_grav[ifqc_pkg::GRAV_W-1:0];

    // weights 0.96 / 0.02 / 0.02, divide by 50 as a reciprocal multiply
    assign temp_num = ifqc_pkg::t_num'(r_temp_value) * ifqc_pkg::t_num'(ifqc_pkg::TEMP_HIST_WEIGHT)
                    + ifqc_pkg::t_num'(s1_sample)
                    + ifqc_pkg::t_num'(r_temp_prev)
                    + ifqc_pkg::t_num'(ifqc_pkg::TEMP_ROUND);
    assign temp_qprod = ifqc_pkg::t_qprod'(temp_num) * ifqc_pkg::t_qprod'(ifqc_pkg::TEMP_RECIP);
    assign temp_next  = temp_qprod[ifqc_pkg::RECIP_SHIFT +: ifqc_pkg::TEMP_OUT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_kept_rt[a]   <= '0;
                r_kept_disp[a] <= '0;
            end
            r_kept_grav   <= '0;
            r_kept_rot    <= '0;
            r_temp_value  <= '0;
            r_temp_prev   <= '0;
            r_temp_primed <= 1'b0;
        end else if (upd) begin
            r_kept_rt   <= r_s1_rt;
            r_kept_disp <= r_s1_disp;
            r_kept_grav <= s1_grav;
            if (s1_grav == ifqc_pkg::GRAV_ROT_A || s1_grav == ifqc_pkg::GRAV_ROT_B) begin
                r_kept_rot <= s1_grav;
            end
            // first good frame seeds the filter
            if (!r_temp_primed) begin
                r_temp_value  <= s1_sample;
                r_temp_primed <= 1'b1;
            end else begin
                r_temp_value <= temp_next;
            end
            r_temp_prev <= s1_sample;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: status of the frame whose state is now kept
    // ------------------------------------------------------------------
    logic r_s2_ok;

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_s2_ok <= s1_ok;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: (angle + offset) * scale, exact products
    // later frames cannot touch the kept state until this word has moved on
    // ------------------------------------------------------------------
    ifqc_pkg::t_prod    p_rt   [3];
    ifqc_pkg::t_prod    p_disp [3];
    ifqc_pkg::t_sum     s_rt   [3];
    ifqc_pkg::t_sum     s_disp [3];

    ifqc_pkg::t_prod    r_p_rt   [3];
    ifqc_pkg::t_prod    r_p_disp [3];
    logic               r_s3_ok;
    ifqc_pkg::t_gravity r_s3_grav;
    ifqc_pkg::t_gravity r_s3_rot;
    ifqc_pkg::t_temp    r_s3_temp;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s_rt[a]   = ifqc_pkg::t_sum'(r_kept_rt[a]) + ifqc_pkg::t_sum'(r_ofs[a]);
            s_disp[a] = ifqc_pkg::t_sum'(r_kept_disp[a]) + ifqc_pkg::t_sum'(r_ofs[a]);
            p_rt[a]   = ifqc_pkg::t_prod'(s_rt[a]) * ifqc_pkg::t_prod'(r_scl[a]);
            p_disp[a] = ifqc_pkg::t_prod'(s_disp[a]) * ifqc_pkg::t_prod'(r_scl[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_p_rt    <= p_rt;
            r_p_disp  <= p_disp;
            r_s3_ok   <= r_s2_ok;
            r_s3_grav <= r_kept_grav;
            r_s3_rot  <= r_kept_rot;
            r_s3_temp <= r_temp_value;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: round, saturate, level angles, wrap; output register
    // ------------------------------------------------------------------
    ifqc_pkg::t_work  c_rt   [3];
    ifqc_pkg::t_work  c_disp [3];
    ifqc_pkg::t_level lh_rt, lv_rt, lh_disp, lv_disp;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_rt[a]   = cal_round_sat(r_p_rt[a]);
            c_disp[a] = cal_round_sat(r_p_disp[a]);
        end
        lh_rt   = level_h(c_rt[1], c_rt[2], r_s3_grav);
        lv_rt   = level_v(c_rt[0], c_rt[2], r_s3_grav);
        lh_disp = level_h(c_disp[1], c_disp[2], r_s3_grav);
        lv_disp = level_v(c_disp[0], c_disp[2], r_s3_grav);
    end

    logic               r_out_status;
    ifqc_pkg::t_gravity r_out_grav;
    ifqc_pkg::t_gravity r_out_rot;
    ifqc_pkg::t_cal     r_out_cal [3];
    ifqc_pkg::t_cal     r_out_lh, r_out_lv, r_out_sh, r_out_sv;
    ifqc_pkg::t_temp    r_out_temp;

    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_out_status <= r_s3_ok ? ifqc_pkg::STATUS_OK : ifqc_pkg::STATUS_REJECT;
            r_out_grav   <= r_s3_grav;
            r_out_rot    <= r_s3_rot;
            for (int a = 0; a < 3; a++) begin
                r_out_cal[a] <= signed'(c_rt[a][ifqc_pkg::OUT_W-1:0]);
            end
            r_out_lh   <= signed'(lh_rt[ifqc_pkg::OUT_W-1:0]);
            r_out_lv   <= signed'(lv_rt[ifqc_pkg::OUT_W-1:0]);
            r_out_sh   <= signed'(lh_disp[ifqc_pkg::OUT_W-1:0]);
            r_out_sv   <= signed'(lv_disp[ifqc_pkg::OUT_W-1:0]);
            r_out_temp <= r_s3_temp;
        end
    end

    assign o_out.valid                = r_v4;
    assign o_out.frame_status         = r_out_status;
    assign o_out.gravity_now          = r_out_grav;
    assign o_out.gravity_rotation     = r_out_rot;
    assign o_out.cal_x                = r_out_cal[0];
    assign o_out.cal_y                = r_out_cal[1];
    assign o_out.cal_z                = r_out_cal[2];
    assign o_out.level_horizontal     = r_out_lh;
    assign o_out.level_vertical       = r_out_lv;
    assign o_out.show_horizontal      = r_out_sh;
    assign o_out.show_vertical        = r_out_sv;
    assign o_out.filtered_temperature = r_out_temp;

endmodule

>>> rtl/ifqc_checker.sv
// port checker for the imu frame qualify and calibrate block, bound to the top level
// depends on ifqc_pkg and imu_frame_qualify_calibrate_unit_macros.svh
`include "imu_frame_qualify_calibrate_unit_macros.svh"

module ifqc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ifqc_pkg::t_gravity i_gravity_now,
    input ifqc_pkg::t_gravity i_gravity_rotation,
    input ifqc_pkg::t_cal     i_cal_x,
    input ifqc_pkg::t_temp    i_filtered_temperature
);

    // a stalled result stays valid and its cal_x stays put
    `IFQC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cal_x), "stalled result word changed")

    // rotation only ever takes the two rotation codes, or its reset value
    `IFQC_ASSERT_SAME(a_rot_code, i_clk, i_rst_n, i_out_valid, i_gravity_rotation == 3'd0 || i_gravity_rotation == ifqc_pkg::GRAV_ROT_A || i_gravity_rotation == ifqc_pkg::GRAV_ROT_B, "bad gravity rotation")

    // only qualified gravity codes are kept
    `IFQC_ASSERT_SAME(a_grav_range, i_clk, i_rst_n, i_out_valid, 8'(i_gravity_now) <= ifqc_pkg::GRAV_MAX, "kept gravity out of range")

    // calibrated angle saturates at +-720 deg
    `IFQC_ASSERT_SAME(a_cal_sat, i_clk, i_rst_n, i_out_valid, (ifqc_pkg::t_work'(i_cal_x) <= ifqc_pkg::CAL_LIMIT) && (ifqc_pkg::t_work'(i_cal_x) >= -ifqc_pkg::CAL_LIMIT), "calibrated x beyond saturation")

    // the filter only sees samples of at most 60 C
    `IFQC_ASSERT_SAME(a_temp_range, i_clk, i_rst_n, i_out_valid, i_filtered_temperature <= ifqc_pkg::TEMP_OUT_MAX, "filtered temperature above window")

endmodule

bind imu_frame_qualify_calibrate_unit ifqc_checker u_ifqc_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_out_valid            (o_out.valid),
    .i_out_ready            (o_out.ready),
    .i_gravity_now          (o_out.gravity_now),
    .i_gravity_rotation     (o_out.gravity_rotation),
    .i_cal_x                (o_out.cal_x),
    .i_filtered_temperature (o_out.filtered_temperature)
);
